[src/gic_pkg.sv]
// Shared types, constants and helpers for the grid island counter.
// Depends on nothing; imported by the parent store, the controller and the top level.
package gic_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int DIM_W     = 6;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] island_count;
        logic             ignored;
    } t_out;

    // One cell of the store: land flag and union-find parent.
    typedef struct packed {
        logic             land;
        logic [IDX_W-1:0] parent;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SELF_RD,
        S_SELF_CHK,
        S_NB_SEL,
        S_NB_CHK,
        S_FIND_P,
        S_FIND_GP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        NB_DOWN,
        NB_UP,
        NB_RIGHT,
        NB_LEFT
    } t_nbr;

    // Limit a dimension register to the store's maximum.
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v, input int maxv);
        if (int'(v) > maxv) begin
            return DIM_W'(maxv);
        end
        return v;
    endfunction

endpackage

[src/gic_store.sv]
// Parent store: one write port, one read port, registered read data.
// Depends on gic_pkg for the entry and request types.
module gic_store
    import gic_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [CELLS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read data holds until the next read; a same-address write is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (i_req.we && (i_req.waddr == i_req.raddr)) begin
                r_rdata <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/gic_ctrl.sv]
// Sequencer for the island counter: clearing sweep, land check, neighbor walk,
// path-halving root search and union. Depends on gic_pkg; drives gic_store.
module gic_ctrl
    import gic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in              i_in,
    input  logic [DIM_W-1:0] i_rows,
    input  logic [DIM_W-1:0] i_cols,
    input  t_entry           i_rdata,
    input  logic             i_res_take,
    output t_mem_req         o_req,
    output logic             o_idle,
    output logic             o_res_valid,
    output t_out             o_res
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_sweep, n_sweep;
    logic             r_clr_item, n_clr_item;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_self, n_self;
    logic [IDX_W-1:0] r_x, n_x;
    logic [IDX_W-1:0] r_rn, n_rn;
    logic             r_phase, n_phase;
    t_nbr             r_k, n_k;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ignored, n_ignored;

    logic                   in_grid;
    logic [ROW_W+DIM_W:0]   self_wide;
    logic                   nb_ok;
    logic [IDX_W-1:0]       nb_idx;
    logic                   last_k;
    logic                   at_root;

    assign in_grid   = (DIM_W'(i_in.row) < i_rows) && (DIM_W'(i_in.col) < i_cols);
    assign self_wide = (ROW_W+DIM_W+1)'(i_in.row) * (ROW_W+DIM_W+1)'(i_cols)
                     + (ROW_W+DIM_W+1)'(i_in.col);
    assign last_k    = (r_k == NB_LEFT);
    assign at_root   = (i_rdata.parent == r_x);

    always_comb begin
        unique case (r_k)
            NB_DOWN: begin
                nb_ok  = (DIM_W'(r_row) + DIM_W'(1)) < i_rows;
                nb_idx = r_self + IDX_W'(i_cols);
            end
            NB_UP: begin
                nb_ok  = (r_row != '0);
                nb_idx = r_self - IDX_W'(i_cols);
            end
            NB_RIGHT: begin
                nb_ok  = (DIM_W'(r_col) + DIM_W'(1)) < i_cols;
                nb_idx = r_self + IDX_W'(1);
            end
            NB_LEFT: begin
                nb_ok  = (r_col != '0);
                nb_idx = r_self - IDX_W'(1);
            end
            default: begin
                nb_ok  = 1'b0;
                nb_idx = r_self;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_sweep == IDX_W'(CELLS - 1)) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    if (i_in.operation == OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (!in_grid) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SELF_RD;
                    end
                end
            end
            S_SELF_RD: n_state = S_SELF_CHK;
            S_SELF_CHK: n_state = i_rdata.land ? S_DONE : S_NB_SEL;
            S_NB_SEL: begin
                if (nb_ok) begin
                    n_state = S_NB_CHK;
                end else begin
                    n_state = last_k ? S_DONE : S_NB_SEL;
                end
            end
            S_NB_CHK: begin
                if (i_rdata.land) begin
                    n_state = S_FIND_P;
                end else begin
                    n_state = last_k ? S_DONE : S_NB_SEL;
                end
            end
            S_FIND_P: begin
                if (!at_root) begin
                    n_state = S_FIND_GP;
                end else if (!r_phase) begin
                    n_state = S_FIND_P;
                end else begin
                    n_state = last_k ? S_DONE : S_NB_SEL;
                end
            end
            S_FIND_GP: n_state = S_FIND_P;
            S_DONE: n_state = i_res_take ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store requests
    always_comb begin
        n_sweep    = r_sweep;
        n_clr_item = r_clr_item;
        n_row      = r_row;
        n_col      = r_col;
        n_self     = r_self;
        n_x        = r_x;
        n_rn       = r_rn;
        n_phase    = r_phase;
        n_k        = r_k;
        n_count    = r_count;
        n_ignored  = r_ignored;
        o_req      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_sweep;
                n_sweep     = r_sweep + IDX_W'(1);
            end
            S_IDLE: begin
                if (i_accept) begin
                    n_row     = i_in.row;
                    n_col     = i_in.col;
                    n_self    = IDX_W'(self_wide);
                    n_ignored = 1'b0;
                    if (i_in.operation == OP_CLEAR) begin
                        n_count    = '0;
                        n_clr_item = 1'b1;
                        n_sweep    = '0;
                    end else if (!in_grid) begin
                        n_ignored = 1'b1;
                    end
                end
            end
            S_SELF_RD: begin
                o_req.re    = 1'b1;
                o_req.raddr = r_self;
            end
            S_SELF_CHK: begin
                if (i_rdata.land) begin
                    n_ignored = 1'b1;
                end else begin
                    o_req.we           = 1'b1;
                    o_req.waddr        = r_self;
                    o_req.wdata.land   = 1'b1;
                    o_req.wdata.parent = r_self;
                    n_count            = r_count + CNT_W'(1);
                    n_k                = NB_DOWN;
                end
            end
            S_NB_SEL: begin
                if (nb_ok) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = nb_idx;
                    n_x         = nb_idx;
                    n_phase     = 1'b0;
                end else begin
                    n_k = t_nbr'(r_k + 2'd1);
                end
            end
            S_NB_CHK: begin
                if (!i_rdata.land) begin
                    n_k = t_nbr'(r_k + 2'd1);
                end
            end
            S_FIND_P: begin
                if (!at_root) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = i_rdata.parent;
                end else if (!r_phase) begin
                    // Neighbor root found; start the search from the new cell.
                    n_rn        = r_x;
                    n_phase     = 1'b1;
                    n_x         = r_self;
                    o_req.re    = 1'b1;
                    o_req.raddr = r_self;
                end else begin
                    if (r_rn != r_x) begin
                        o_req.we           = 1'b1;
                        o_req.waddr        = r_x;
                        o_req.wdata.land   = 1'b1;
                        o_req.wdata.parent = r_rn;
                        n_count            = r_count - CNT_W'(1);
                    end
                    n_k = t_nbr'(r_k + 2'd1);
                end
            end
            S_FIND_GP: begin
                // Halve the path: point x at its grandparent and move there.
                o_req.we           = 1'b1;
                o_req.waddr        = r_x;
                o_req.wdata.land   = 1'b1;
                o_req.wdata.parent = i_rdata.parent;
                o_req.re           = 1'b1;
                o_req.raddr        = i_rdata.parent;
                n_x                = i_rdata.parent;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_clr_item = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_sweep    <= '0;
            r_clr_item <= 1'b0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_sweep    <= n_sweep;
            r_clr_item <= n_clr_item;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_col     <= n_col;
        r_self    <= n_self;
        r_x       <= n_x;
        r_rn      <= n_rn;
        r_phase   <= n_phase;
        r_k       <= n_k;
        r_ignored <= n_ignored;
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_DONE);
    assign o_res.island_count = r_count;
    assign o_res.ignored      = r_ignored;

endmodule

[src/grid_island_count_path_halving.sv]
// Top level of the online grid island counter (union-find, path halving).
// Depends on gic_pkg, gic_store and gic_ctrl.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_in_data  (operation,row,col)
//  out     | out of    | o_out_valid / i_out_stall  | o_out_data (island_count,ignored)
//  cfg     | into      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Once a result is loaded into the output register, the sequencer returns to idle and
// takes the next transaction there. An add of a new in-grid cell reads the cell, marks
// it as land and its own root, then visits each neighbor: one off the grid is skipped,
// water is passed over, and land leads to two root searches, from the neighbor and from
// the new cell, each a run of halving steps (a read, then a read plus write-back, paced
// by the registered store read data), then a union if the roots differ. A repeated cell
// and an off-grid add are reported as ignored. A clear wipes one store entry per cycle,
// then gives the result. After reset the same clearing pass runs with o_in_stall high.
// The output register lets a result wait under i_out_stall while the next item runs.
module grid_island_count_path_halving
    import gic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0] r_grid_rows;
    logic [DIM_W-1:0] r_grid_cols;
    logic [DIM_W-1:0] rows_used;
    logic [DIM_W-1:0] cols_used;

    logic             r_out_valid;
    t_out             r_out_data;

    logic             in_accept;
    logic             ctrl_idle;
    logic             res_valid;
    t_out             res;
    logic             res_take;
    t_mem_req         mem_req;
    t_entry           mem_rdata;

    // Configuration registers: always ready, writes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_W'(32);
            r_grid_cols <= DIM_W'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Oversized dimensions act as the store's maximum.
    assign rows_used = dim_clamp(r_grid_rows, MAX_ROWS);
    assign cols_used = dim_clamp(r_grid_cols, MAX_COLS);

    // Take a new transaction only when the sequencer is idle.
    assign o_in_stall = !ctrl_idle;
    assign in_accept  = i_in_valid && !o_in_stall;

    gic_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    gic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_in        (i_in_data),
        .i_rows      (rows_used),
        .i_cols      (cols_used),
        .i_rdata     (mem_rdata),
        .i_res_take  (res_take),
        .o_req       (mem_req),
        .o_idle      (ctrl_idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register: load when empty or when its transaction leaves this cycle.
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // An accepted item leaves the sequencer busy, so the input stalls in the cycle after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input accepted on two consecutive cycles");

    // The island count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.island_count <= CNT_W'(CELLS)))
        else $error("island count above cell total");

    // The forest is acyclic, so a write-back never hits the entry read alongside it.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("parent store read and write at the same entry");
`endif

endmodule
